>>> sv/dual_pid_voltage_limit_controller_macros.svh
// Assertion helpers used by the checker file.
`ifndef DUAL_PID_VOLTAGE_LIMIT_CONTROLLER_MACROS_SVH
`define DUAL_PID_VOLTAGE_LIMIT_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPVL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define DPVL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dpvl_pkg.sv
`default_nettype none

package dpvl_pkg;

   // Field widths of the sample and result words.
   localparam int ADC_BITS  = 12;
   localparam int ERR_W     = ADC_BITS + 1;
   localparam int DUTY_W    = 12;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 3;

   // Loop arithmetic.
   localparam int PWM_SHIFT    = 14;
   localparam int GAIN_BITS    = 16;
   localparam int GAIN_FIELD_W = 16;
   localparam int GAIN_REG_W   = 3 * GAIN_FIELD_W;
   localparam int INT_W        = 40;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = GAIN_REG_W;

   localparam logic [ADC_BITS-1:0] ADC_MAX  = '1;
   localparam logic [DUTY_W-1:0]   DUTY_MAX = '1;

   // Command codes carried in the mode field; any other code is a sample.
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

   // Status codes of the result word.
   localparam logic [STATUS_W-1:0] STATUS_REGULATING = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_IDLE       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER_VOLT  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNDER_VOLT = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FAULT      = 3'd4;

   // Register map.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_FLOOR = 3'd0,
      CSR_VOUT_LIMIT   = 3'd1,
      CSR_VOUT_ABS_MAX = 3'd2,
      CSR_VIN_ABS_MIN  = 3'd3,
      CSR_IN_GAINS     = 3'd4,
      CSR_OUT_GAINS    = 3'd5,
      CSR_PWM_FLOOR    = 3'd6,
      CSR_PWM_CEILING  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ADC_BITS-1:0]   target_floor;
      logic [ADC_BITS-1:0]   vout_limit;
      logic [ADC_BITS-1:0]   vout_abs_max;
      logic [ADC_BITS-1:0]   vin_abs_min;
      logic [GAIN_REG_W-1:0] in_gains;
      logic [GAIN_REG_W-1:0] out_gains;
      logic [DUTY_W-1:0]     pwm_floor;
      logic [DUTY_W-1:0]     pwm_ceiling;
   } cfg_type;

   // Control of one PID loop's state.
   typedef struct packed {
      logic clear;
      logic run;
   } loop_ctl_type;

endpackage

`default_nettype wire

>>> sv/dpvl_if.sv
`default_nettype none

// Sample channel: one word per ADC sample set or command.
interface dpvl_req_if;
   logic                          valid;
   logic                          ready;
   logic [dpvl_pkg::MODE_W-1:0]   mode;
   logic [dpvl_pkg::ADC_BITS-1:0] vout_sample;
   logic [dpvl_pkg::ADC_BITS-1:0] vin_sample;
   logic                          fault_n;
   logic [dpvl_pkg::ADC_BITS-1:0] vin_target;

   modport source (output valid, mode, vout_sample, vin_sample, fault_n, vin_target,
                   input ready);
   modport sink (input valid, mode, vout_sample, vin_sample, fault_n, vin_target,
                 output ready);
endinterface

// Result channel: one word per sample word.
interface dpvl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dpvl_pkg::DUTY_W-1:0]   pwm_duty;
   logic [dpvl_pkg::STATUS_W-1:0] status;
   logic                          output_loop_active;
   logic                          saturated;

   modport source (output valid, pwm_duty, status, output_loop_active, saturated,
                   input ready);
   modport sink (input valid, pwm_duty, status, output_loop_active, saturated,
                 output ready);
endinterface

`default_nettype wire

>>> sv/dpvl_csr.sv
`default_nettype none

module dpvl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [dpvl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dpvl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output dpvl_pkg::cfg_type                      cfg
);

   dpvl_pkg::cfg_type cfg_ff;
   dpvl_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register; narrow registers keep the low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (dpvl_pkg::csr_index_type'(csr_index))
            dpvl_pkg::CSR_TARGET_FLOOR: cfg_in.target_floor = csr_wdata[dpvl_pkg::ADC_BITS-1:0];
            dpvl_pkg::CSR_VOUT_LIMIT:   cfg_in.vout_limit   = csr_wdata[dpvl_pkg::ADC_BITS-1:0];
            dpvl_pkg::CSR_VOUT_ABS_MAX: cfg_in.vout_abs_max = csr_wdata[dpvl_pkg::ADC_BITS-1:0];
            dpvl_pkg::CSR_VIN_ABS_MIN:  cfg_in.vin_abs_min  = csr_wdata[dpvl_pkg::ADC_BITS-1:0];
            dpvl_pkg::CSR_IN_GAINS:     cfg_in.in_gains     = csr_wdata;
            dpvl_pkg::CSR_OUT_GAINS:    cfg_in.out_gains    = csr_wdata;
            dpvl_pkg::CSR_PWM_FLOOR:    cfg_in.pwm_floor    = csr_wdata[dpvl_pkg::DUTY_W-1:0];
            dpvl_pkg::CSR_PWM_CEILING:  cfg_in.pwm_ceiling  = csr_wdata[dpvl_pkg::DUTY_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_floor <= '0;
         cfg_ff.vout_limit   <= dpvl_pkg::ADC_MAX;
         cfg_ff.vout_abs_max <= dpvl_pkg::ADC_MAX;
         cfg_ff.vin_abs_min  <= '0;
         cfg_ff.in_gains     <= '0;
         cfg_ff.out_gains    <= '0;
         cfg_ff.pwm_floor    <= '0;
         cfg_ff.pwm_ceiling  <= dpvl_pkg::DUTY_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/dpvl_pid_loop.sv
`default_nettype none

module dpvl_pid_loop #(
   parameter int GAIN_BITS = dpvl_pkg::GAIN_BITS,
   parameter int PWM_SHIFT = dpvl_pkg::PWM_SHIFT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  dpvl_pkg::loop_ctl_type                       ctl,
   input  wire logic signed [dpvl_pkg::ERR_W-1:0]       err,
   input  wire logic [dpvl_pkg::GAIN_REG_W-1:0]         gains,
   input  wire logic [dpvl_pkg::DUTY_W-1:0]             pwm_floor,
   input  wire logic [dpvl_pkg::DUTY_W-1:0]             pwm_ceiling,
   output logic [dpvl_pkg::DUTY_W+PWM_SHIFT-1:0]        drive,
   output logic [dpvl_pkg::DUTY_W+PWM_SHIFT-1:0]        prev_drive_in
);

   localparam int ERR_W   = dpvl_pkg::ERR_W;
   localparam int INT_W   = dpvl_pkg::INT_W;
   localparam int GF_W    = dpvl_pkg::GAIN_FIELD_W;
   localparam int DRIVE_W = dpvl_pkg::DUTY_W + PWM_SHIFT;
   localparam int K_W     = GAIN_BITS + 1;
   localparam int PROD_W  = ERR_W + K_W;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int DPROD_W = DIFF_W + K_W;
   localparam int PD_W    = DPROD_W + 1;
   localparam int V_W     = INT_W + 1;

   logic signed [INT_W-1:0]   integral_ff, integral_in;
   logic signed [ERR_W-1:0]   prev_error_ff;
   logic [DRIVE_W-1:0]        prev_drive_ff;

   logic signed [K_W-1:0]     kp, ki, kd;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  p_term, i_term;
   logic signed [DPROD_W-1:0] d_term;
   logic signed [PD_W-1:0]    pd;
   logic signed [V_W-1:0]     int_sum, pd_x, v, v_rl, v_fin;
   logic signed [INT_W-1:0]   int_sat, int_fix;
   logic [DRIVE_W-1:0]        top, bot, step;
   logic [DRIVE_W:0]          limit;
   logic signed [V_W-1:0]     limit_x, top_x, bot_x;
   logic                      rate_hit, top_hit, bot_hit;

   // Gains are unsigned; a zero sign bit makes them signed multiplier operands.
   assign kp = $signed({1'b0, gains[0 +: GAIN_BITS]});
   assign ki = $signed({1'b0, gains[GF_W +: GAIN_BITS]});
   assign kd = $signed({1'b0, gains[2*GF_W +: GAIN_BITS]});

   // Proportional, derivative and integral terms.
   assign diff   = DIFF_W'(err) - DIFF_W'(prev_error_ff);
   assign p_term = PROD_W'(err) * PROD_W'(kp);
   assign i_term = PROD_W'(err) * PROD_W'(ki);
   assign d_term = DPROD_W'(diff) * DPROD_W'(kd);
   assign pd     = PD_W'(p_term) + PD_W'(d_term);
   assign pd_x   = V_W'(pd);

   // Integral accumulates with saturation at the signed bounds.
   assign int_sum = V_W'(integral_ff) + V_W'(i_term);
   assign int_sat = (int_sum[V_W-1] != int_sum[V_W-2])
                    ? {int_sum[V_W-1], {(INT_W-1){~int_sum[V_W-1]}}}
                    : int_sum[INT_W-1:0];
   assign v = pd_x + V_W'(int_sat);

   // Drive bounds and the rise limit of one eighth of the ceiling.
   assign top     = {pwm_ceiling, PWM_SHIFT'(0)};
   assign bot     = {pwm_floor, PWM_SHIFT'(0)};
   assign step    = top >> 3;
   assign limit   = (DRIVE_W+1)'(prev_drive_ff) + (DRIVE_W+1)'(step);
   assign limit_x = V_W'($signed({1'b0, limit}));
   assign top_x   = V_W'($signed({1'b0, top}));
   assign bot_x   = V_W'($signed({1'b0, bot}));

   assign rate_hit = v > limit_x;
   assign v_rl     = rate_hit ? limit_x : v;

   // Ceiling is tested before the floor.
   always_comb begin
      top_hit = v_rl > top_x;
      bot_hit = !top_hit && (v_rl < bot_x);
      if (top_hit) begin
         v_fin = top_x;
      end else if (bot_hit) begin
         v_fin = bot_x;
      end else begin
         v_fin = v_rl;
      end
   end

   // Anti-windup: when the drive was limited, the integral takes up the difference.
   assign int_fix     = INT_W'(v_fin - pd_x);
   assign integral_in = (rate_hit || top_hit || bot_hit) ? int_fix : int_sat;

   assign drive = v_fin[DRIVE_W-1:0];

   always_comb begin
      if (ctl.clear) begin
         prev_drive_in = '0;
      end else if (ctl.run) begin
         prev_drive_in = drive;
      end else begin
         prev_drive_in = prev_drive_ff;
      end
   end

   // Loop state.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         integral_ff   <= '0;
         prev_error_ff <= '0;
         prev_drive_ff <= '0;
      end else if (ctl.run) begin
         integral_ff   <= integral_in;
         prev_error_ff <= err;
         prev_drive_ff <= drive;
      end
   end

endmodule

`default_nettype wire

>>> sv/dual_pid_voltage_limit_controller.sv
// Dual-loop PID voltage controller with min-select of the two drives.
//
// Sample words arrive on req_chan (valid/ready) and carry a mode, the output
// and input voltage readings, the fault line and the input-voltage target.
// Every word yields exactly one result word on rsp_chan: PWM duty, status, which
// loop governs and whether the input loop sits at the ceiling. The user must see
// registers written via csr_we/csr_index/csr_wdata only while idle; not enforced.
//
// A word passes through the input register and then the result register, from
// which the result is offered. Both loops run in the cycle that moves a word
// from the input register into the result register, so one word is taken per
// cycle with rsp ready high.
//
// Reset (synchronous, active high) clears both loops, leaves tracking off
// and loads the registers with their reset values. When the receiver holds
// rsp ready low, the result word is held, one further word waits in the
// input register, and req ready then falls until the result is taken.
`default_nettype none

module dual_pid_voltage_limit_controller #(
   parameter int GAIN_BITS = dpvl_pkg::GAIN_BITS,
   parameter int PWM_SHIFT = dpvl_pkg::PWM_SHIFT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dpvl_req_if.sink                               req_chan,
   dpvl_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [dpvl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dpvl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADC_BITS = dpvl_pkg::ADC_BITS;
   localparam int ERR_W    = dpvl_pkg::ERR_W;
   localparam int DUTY_W   = dpvl_pkg::DUTY_W;
   localparam int DRIVE_W  = DUTY_W + PWM_SHIFT;

   dpvl_pkg::cfg_type cfg;

   // Input register.
   logic                          s1_valid_ff;
   logic [dpvl_pkg::MODE_W-1:0]   mode_ff;
   logic [ADC_BITS-1:0]           vout_ff, vin_ff, target_ff;
   logic                          fault_n_ff;

   // Result register and controller state.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]             duty_ff, duty_in;
   logic [dpvl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          active_ff;
   logic                          sat_ff, sat_in;
   logic                          tracking_ff, tracking_in;
   logic                          loop_flag_ff, loop_flag_in;

   logic                          req_acc, move, run_loops, start_cmd;
   logic [ADC_BITS-1:0]           target;
   logic signed [ERR_W-1:0]       in_err, out_err;
   dpvl_pkg::loop_ctl_type        loop_ctl;
   logic [DRIVE_W-1:0]            in_drive, out_drive, in_prev_drive, out_prev_drive;
   logic [DRIVE_W-1:0]            sel_drive, top;

   dpvl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: a word moves on when the result register is free or being taken.
   assign move           = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff    <= req_chan.mode;
         vout_ff    <= req_chan.vout_sample;
         vin_ff     <= req_chan.vin_sample;
         fault_n_ff <= req_chan.fault_n;
         target_ff  <= req_chan.vin_target;
      end
   end

   // Target clamped up to the floor, and the two loop errors.
   assign target  = (target_ff < cfg.target_floor) ? cfg.target_floor : target_ff;
   assign in_err  = $signed({1'b0, vin_ff}) - $signed({1'b0, target});
   assign out_err = $signed({1'b0, vout_ff}) - $signed({1'b0, cfg.vout_limit});

   dpvl_pid_loop #(
      .GAIN_BITS (GAIN_BITS),
      .PWM_SHIFT (PWM_SHIFT)
   ) u_in_loop (
      .clock         (clock),
      .reset         (reset),
      .ctl           (loop_ctl),
      .err           (in_err),
      .gains         (cfg.in_gains),
      .pwm_floor     (cfg.pwm_floor),
      .pwm_ceiling   (cfg.pwm_ceiling),
      .drive         (in_drive),
      .prev_drive_in (in_prev_drive)
   );

   dpvl_pid_loop #(
      .GAIN_BITS (GAIN_BITS),
      .PWM_SHIFT (PWM_SHIFT)
   ) u_out_loop (
      .clock         (clock),
      .reset         (reset),
      .ctl           (loop_ctl),
      .err           (out_err),
      .gains         (cfg.out_gains),
      .pwm_floor     (cfg.pwm_floor),
      .pwm_ceiling   (cfg.pwm_ceiling),
      .drive         (out_drive),
      .prev_drive_in (out_prev_drive)
   );

   // Command decode and the protection checks, in priority order.
   always_comb begin
      tracking_in  = tracking_ff;
      loop_flag_in = loop_flag_ff;
      duty_in      = cfg.pwm_floor;
      status_in    = dpvl_pkg::STATUS_REGULATING;
      run_loops    = 1'b0;
      start_cmd    = 1'b0;
      sel_drive    = (out_drive <= in_drive) ? out_drive : in_drive;
      unique case (mode_ff)
         dpvl_pkg::MODE_START: begin
            start_cmd    = 1'b1;
            loop_flag_in = 1'b0;
            tracking_in  = 1'b1;
         end
         dpvl_pkg::MODE_STOP: begin
            tracking_in = 1'b0;
            status_in   = dpvl_pkg::STATUS_IDLE;
         end
         default: begin
            if (vout_ff > cfg.vout_abs_max) begin
               tracking_in = 1'b0;
               status_in   = dpvl_pkg::STATUS_OVER_VOLT;
            end else if (vin_ff < cfg.vin_abs_min) begin
               tracking_in = 1'b0;
               status_in   = dpvl_pkg::STATUS_UNDER_VOLT;
            end else if (!tracking_ff) begin
               status_in = dpvl_pkg::STATUS_IDLE;
            end else if (!fault_n_ff) begin
               tracking_in = 1'b0;
               status_in   = dpvl_pkg::STATUS_FAULT;
            end else begin
               run_loops    = 1'b1;
               loop_flag_in = out_drive <= in_drive;
               duty_in      = sel_drive[PWM_SHIFT +: DUTY_W];
            end
         end
      endcase
   end

   assign loop_ctl.clear = move && start_cmd;
   assign loop_ctl.run   = move && run_loops;

   // Saturation flag looks at the input loop's drive as left by this word.
   assign top    = {cfg.pwm_ceiling, PWM_SHIFT'(0)};
   assign sat_in = in_prev_drive >= top;

   always_comb begin
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tracking_ff  <= 1'b0;
         loop_flag_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            tracking_ff  <= tracking_in;
            loop_flag_ff <= loop_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         duty_ff   <= duty_in;
         status_ff <= status_in;
         active_ff <= loop_flag_in;
         sat_ff    <= sat_in;
      end
   end

   // out_prev_drive is only needed inside its loop; fold it into nothing visible.
   logic unused_out_prev;
   assign unused_out_prev = ^out_prev_drive;

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.pwm_duty           = duty_ff;
   assign rsp_chan.status             = status_ff;
   assign rsp_chan.output_loop_active = active_ff;
   assign rsp_chan.saturated          = sat_ff;

endmodule

`default_nettype wire

>>> sv/dpvl_checker.sv
`default_nettype none
`include "dual_pid_voltage_limit_controller_macros.svh"

module dpvl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [dpvl_pkg::MODE_W-1:0]       req_mode,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [dpvl_pkg::DUTY_W-1:0]       rsp_pwm_duty,
   input wire logic [dpvl_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic                              rsp_output_loop_active
);

   // The input side only stalls behind a result word that is not being taken.
   `DPVL_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "req stalled without a held result")

   // With the receiver ready, an accepted word passes the input register and comes out of the result register.
   `DPVL_ASSERT_NEXT(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready, rsp_valid, "result word missing after two cycles")

   // A start word reports regulating with the input loop selected.
   `DPVL_ASSERT_NEXT(a_start_result, clock, reset, (req_valid && req_ready && req_mode == dpvl_pkg::MODE_START) ##1 rsp_ready, rsp_status == dpvl_pkg::STATUS_REGULATING && !rsp_output_loop_active, "start word gave wrong result")

   // A stalled result word holds.
   `DPVL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pwm_duty) && $stable(rsp_status), "stalled result word changed")

endmodule

bind dual_pid_voltage_limit_controller dpvl_checker u_dpvl_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_chan.valid),
   .req_ready              (req_chan.ready),
   .req_mode               (req_chan.mode),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_pwm_duty           (rsp_chan.pwm_duty),
   .rsp_status             (rsp_chan.status),
   .rsp_output_loop_active (rsp_chan.output_loop_active)
);

`default_nettype wire

>>> dv/dual_pid_voltage_limit_controller_tb.sv
`timescale 1ns / 100ps

module dual_pid_voltage_limit_controller_tb;
   import dpvl_pkg::*;

   // The spare mode code is handled as a plain sample by the block.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int     IN_LOOP      = 0;
   localparam int     OUT_LOOP     = 1;
   localparam longint INT40_HI     = 64'sd549755813887;
   localparam longint INT40_LO     = -64'sd549755813888;
   localparam int     QUIET_LIMIT  = 3000;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ADC_BITS-1:0] vout;
      logic [ADC_BITS-1:0] vin;
      logic                fault_n;
      logic [ADC_BITS-1:0] target;
   } sample_word_t;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty;
      logic [STATUS_W-1:0] status;
      logic                out_loop;
      logic                saturated;
   } duty_word_t;

   typedef struct {
      logic signed [INT_W-1:0] integral;
      logic signed [ERR_W-1:0] last_error;
      logic signed [INT_W-1:0] last_drive;
   } pid_state_t;

   typedef enum int {TYPICAL, WIDE_OPEN, PINCHED} settings_flavour_t;

   logic clock = 1'b0;
   logic reset;
   logic                    csr_we;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   dpvl_req_if req_ch ();
   dpvl_rsp_if rsp_ch ();

   dual_pid_voltage_limit_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_ch),
      .rsp_chan  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Controller state as the testbench sees it.
   cfg_type     ctl_cfg;
   pid_state_t  pid_loops [2];
   logic        tracking;
   logic        governs_out;
   duty_word_t  duty_words_due [$];

   int   mismatch_count = 0;
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   logic hold_request   = 1'b0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;

   // Saturate a value to the signed 40-bit range of the integrators.
   function automatic longint clamp_int40(input longint v);
      if (v > INT40_HI) return INT40_HI;
      if (v < INT40_LO) return INT40_LO;
      return v;
   endfunction

   // One PID update with rate limit, PWM bounds and anti-windup.
   function automatic longint run_pid(input int idx, input longint err);
      logic [GAIN_REG_W-1:0] g;
      longint kp, ki, kd, top, bot, step, pd, acc, v;
      g    = (idx == IN_LOOP) ? ctl_cfg.in_gains : ctl_cfg.out_gains;
      kp   = longint'(g[GAIN_FIELD_W-1:0]);
      ki   = longint'(g[2*GAIN_FIELD_W-1:GAIN_FIELD_W]);
      kd   = longint'(g[3*GAIN_FIELD_W-1:2*GAIN_FIELD_W]);
      top  = longint'(ctl_cfg.pwm_ceiling) << PWM_SHIFT;
      bot  = longint'(ctl_cfg.pwm_floor) << PWM_SHIFT;
      step = top / 8;
      pd   = err * kp + kd * (err - longint'(pid_loops[idx].last_error));
      acc  = clamp_int40(longint'(pid_loops[idx].integral) + err * ki);
      v    = pd + acc;
      if (v - longint'(pid_loops[idx].last_drive) > step) begin
         v   = longint'(pid_loops[idx].last_drive) + step;
         acc = clamp_int40(v - pd);
      end
      // The ceiling is tested first, so with a floor above the ceiling a drive over the ceiling gets the ceiling.
      if (v > top) begin
         v   = top;
         acc = clamp_int40(v - pd);
      end else if (v < bot) begin
         v   = bot;
         acc = clamp_int40(v - pd);
      end
      pid_loops[idx].integral   = acc[INT_W-1:0];
      pid_loops[idx].last_drive = v[INT_W-1:0];
      pid_loops[idx].last_error = err[ERR_W-1:0];
      return v;
   endfunction

   function automatic void clear_loops();
      for (int i = 0; i < 2; i++) begin
         pid_loops[i].integral   = '0;
         pid_loops[i].last_error = '0;
         pid_loops[i].last_drive = '0;
      end
   endfunction

   // Work out the result word that one accepted sample word yields.
   function automatic duty_word_t compute_duty_word(input sample_word_t w);
      duty_word_t r;
      logic [ADC_BITS-1:0] tgt;
      longint od, id, sel;
      r.duty = ctl_cfg.pwm_floor;
      tgt = (w.target < ctl_cfg.target_floor) ? ctl_cfg.target_floor : w.target;
      if (w.mode == MODE_START) begin
         clear_loops();
         governs_out = 1'b0;
         tracking    = 1'b1;
         r.status    = STATUS_REGULATING;
      end else if (w.mode == MODE_STOP) begin
         tracking = 1'b0;
         r.status = STATUS_IDLE;
      end else if (w.vout > ctl_cfg.vout_abs_max) begin
         tracking = 1'b0;
         r.status = STATUS_OVER_VOLT;
      end else if (w.vin < ctl_cfg.vin_abs_min) begin
         tracking = 1'b0;
         r.status = STATUS_UNDER_VOLT;
      end else if (!tracking) begin
         r.status = STATUS_IDLE;
      end else if (!w.fault_n) begin
         tracking = 1'b0;
         r.status = STATUS_FAULT;
      end else begin
         od  = run_pid(OUT_LOOP, longint'(w.vout) - longint'(ctl_cfg.vout_limit));
         id  = run_pid(IN_LOOP, longint'(w.vin) - longint'(tgt));
         sel = (od < id) ? od : id;
         if (sel < 0) sel = 0;
         r.duty      = sel[PWM_SHIFT +: DUTY_W];
         governs_out = !(od > id);
         r.status    = STATUS_REGULATING;
      end
      r.out_loop  = governs_out;
      r.saturated = longint'(pid_loops[IN_LOOP].last_drive) >=
                    (longint'(ctl_cfg.pwm_ceiling) << PWM_SHIFT);
      return r;
   endfunction

   function automatic sample_word_t make_word(input logic [MODE_W-1:0] mode, input int vout,
                                              input int vin, input logic fault_n,
                                              input int target);
      sample_word_t w;
      w.mode    = mode;
      w.vout    = vout[ADC_BITS-1:0];
      w.vin     = vin[ADC_BITS-1:0];
      w.fault_n = fault_n;
      w.target  = target[ADC_BITS-1:0];
      return w;
   endfunction

   function automatic sample_word_t random_word();
      return make_word($urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 1), $urandom_range(0, 4095));
   endfunction

   function automatic logic [GAIN_REG_W-1:0] pack_gains(input int kp, input int ki, input int kd);
      return {kd[GAIN_FIELD_W-1:0], ki[GAIN_FIELD_W-1:0], kp[GAIN_FIELD_W-1:0]};
   endfunction

   // Gains spread over many magnitudes, with zero fields now and then.
   function automatic logic [GAIN_REG_W-1:0] random_gains();
      return pack_gains($urandom_range(0, 65535) >> $urandom_range(0, 16),
                        $urandom_range(0, 65535) >> $urandom_range(0, 16),
                        $urandom_range(0, 65535) >> $urandom_range(0, 16));
   endfunction

   function automatic int fit(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic cfg_type random_settings(input settings_flavour_t flavour);
      cfg_type c;
      c.target_floor = $urandom_range(0, 2500);
      c.vout_limit   = $urandom_range(1500, 4095);
      c.vout_abs_max = $urandom_range(3000, 4095);
      c.vin_abs_min  = $urandom_range(0, 1000);
      c.in_gains     = random_gains();
      c.out_gains    = random_gains();
      c.pwm_floor    = $urandom_range(0, 1000);
      c.pwm_ceiling  = $urandom_range(2000, 4095);
      case (flavour)
         WIDE_OPEN: begin
            c.target_floor = ADC_MAX;
            c.vout_limit   = '0;
            c.vout_abs_max = ADC_MAX;
            c.vin_abs_min  = '0;
            c.in_gains     = '1;
            c.out_gains    = '1;
            c.pwm_floor    = '0;
            c.pwm_ceiling  = DUTY_MAX;
         end
         PINCHED: begin
            c.target_floor = '0;
            c.vout_limit   = ADC_MAX;
            c.vout_abs_max = '0;
            c.vin_abs_min  = ADC_MAX;
            c.in_gains     = '0;
            c.out_gains    = '0;
            c.pwm_floor    = '0;
            c.pwm_ceiling  = '0;
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("%0t: %s", $time, what);
   endtask

   // Offer one sample word and record its expected result once accepted.
   task automatic send_word(input sample_word_t w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= w.mode;
      req_ch.vout_sample <= w.vout;
      req_ch.vin_sample  <= w.vin;
      req_ch.fault_n     <= w.fault_n;
      req_ch.vin_target  <= w.target;
      do @(negedge clock); while (!req_ch.ready);
      duty_words_due.push_back(compute_duty_word(w));
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (duty_words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Registers change only once every result is back.
   task automatic apply_settings(input cfg_type c);
      wait_drained();
      write_csr(CSR_TARGET_FLOOR, CSR_DATA_W'(c.target_floor));
      write_csr(CSR_VOUT_LIMIT,   CSR_DATA_W'(c.vout_limit));
      write_csr(CSR_VOUT_ABS_MAX, CSR_DATA_W'(c.vout_abs_max));
      write_csr(CSR_VIN_ABS_MIN,  CSR_DATA_W'(c.vin_abs_min));
      write_csr(CSR_IN_GAINS,     c.in_gains);
      write_csr(CSR_OUT_GAINS,    c.out_gains);
      write_csr(CSR_PWM_FLOOR,    CSR_DATA_W'(c.pwm_floor));
      write_csr(CSR_PWM_CEILING,  CSR_DATA_W'(c.pwm_ceiling));
      csr_we  <= 1'b0;
      ctl_cfg = c;
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      @(posedge clock);
   endtask

   // Mostly tracking runs around a drifting operating point; the rest is noise,
   // faults and stop commands.
   task automatic random_words(input int count);
      int sent, run_len, roll, vout_op, vin_op, tgt_op;
      sent = 0;
      while (sent < count) begin
         send_word(make_word(MODE_START, $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 1), $urandom_range(0, 4095)));
         sent++;
         run_len = $urandom_range(4, 40);
         tgt_op  = $urandom_range(0, 4095);
         vout_op = fit(int'(ctl_cfg.vout_limit) + int'($urandom_range(0, 400)) - 200,
                       0, ctl_cfg.vout_abs_max);
         vin_op  = fit(tgt_op + int'($urandom_range(0, 400)) - 200, ctl_cfg.vin_abs_min, 4095);
         for (int k = 0; k < run_len && sent < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 85) begin
               if ($urandom_range(15) == 0) tgt_op = $urandom_range(0, 4095);
               vout_op = fit(vout_op + int'($urandom_range(0, 128)) - 64, 0,
                             ctl_cfg.vout_abs_max);
               vin_op  = fit(vin_op + int'($urandom_range(0, 128)) - 64, ctl_cfg.vin_abs_min,
                             4095);
               send_word(make_word(($urandom_range(9) == 0) ? MODE_SPARE : MODE_SAMPLE,
                                   vout_op, vin_op, 1'b1, tgt_op));
            end else if (roll < 92) begin
               send_word(random_word());
            end else if (roll < 96) begin
               send_word(make_word(MODE_SAMPLE, vout_op, vin_op, 1'b0, tgt_op));
            end else begin
               send_word(make_word(MODE_STOP, vout_op, vin_op, 1'b1, tgt_op));
            end
            sent++;
         end
      end
   endtask

   // Commands and samples under the reset settings.
   task automatic test_idle_commands();
      send_word(make_word(MODE_SAMPLE, 100, 2000, 1'b1, 1000));
      send_word(make_word(MODE_SPARE, 0, 4095, 1'b0, 4095));
      send_word(make_word(MODE_STOP, 4095, 0, 1'b1, 0));
      send_word(make_word(MODE_START, 0, 0, 1'b0, 0));
      send_word(make_word(MODE_SAMPLE, 2000, 2000, 1'b1, 2000));
   endtask

   // Over-voltage beats under-voltage beats idle beats fault.
   task automatic test_panic_order();
      apply_settings('{target_floor: 1000, vout_limit: 3000, vout_abs_max: 3800,
                       vin_abs_min: 200, in_gains: pack_gains(300, 20, 100),
                       out_gains: pack_gains(500, 30, 50), pwm_floor: 100,
                       pwm_ceiling: 3900});
      send_word(make_word(MODE_SAMPLE, 3801, 1500, 1'b1, 1200));
      send_word(make_word(MODE_SAMPLE, 2900, 199, 1'b1, 1200));
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 2900, 1500, 1'b1, 1200));
      send_word(make_word(MODE_SAMPLE, 3801, 1500, 1'b1, 1200));
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 2900, 199, 1'b1, 1200));
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 3900, 100, 1'b0, 1200));
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 2900, 1500, 1'b0, 1200));
      send_word(make_word(MODE_SAMPLE, 2900, 1500, 1'b0, 1200));
   endtask

   // Readings and targets at their extremes, with the target clamped to its floor.
   task automatic test_field_extremes();
      apply_settings('{target_floor: 1500, vout_limit: 2500, vout_abs_max: 4095,
                       vin_abs_min: 0, in_gains: pack_gains(40, 8, 20),
                       out_gains: pack_gains(60, 4, 10), pwm_floor: 0,
                       pwm_ceiling: 4095});
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 0, 4095, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 4095, 4095, 1'b1, 4095));
      send_word(make_word(MODE_SAMPLE, 2500, 0, 1'b1, 4095));
      send_word(make_word(MODE_SPARE, 2500, 1500, 1'b1, 1500));
      send_word(make_word(MODE_STOP, 2500, 1500, 1'b1, 1500));
   endtask

   // A floor above the ceiling: the drive goes to the ceiling when above it, else to the floor.
   task automatic test_floor_above_ceiling();
      apply_settings('{target_floor: 0, vout_limit: 4095, vout_abs_max: 4095,
                       vin_abs_min: 0, in_gains: '1, out_gains: '1, pwm_floor: 4095,
                       pwm_ceiling: 0});
      send_word(make_word(MODE_START, 0, 0, 1'b1, 0));
      send_word(make_word(MODE_SAMPLE, 1000, 3000, 1'b1, 2000));
      send_word(make_word(MODE_SAMPLE, 4095, 0, 1'b1, 4095));
      send_word(make_word(MODE_SPARE, 0, 4095, 1'b1, 0));
   endtask

   // The receiver holds off long enough for the block to stop taking words.
   task automatic test_backpressure();
      apply_settings(random_settings(TYPICAL));
      set_idling(0, 0);
      @(negedge clock);
      hold_request = 1'b1;
      @(posedge clock);
      random_words(40);
   endtask

   task automatic test_random_phase(input settings_flavour_t flavour, input int send_pct,
                                    input int stall_pct, input int count);
      apply_settings(random_settings(flavour));
      set_idling(send_pct, stall_pct);
      random_words(count);
   endtask

   // Receiver: random stalls, or a long hold when one is requested.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Result check and watchdog, sampled at the falling edge before the edge that moves a word.
   always @(negedge clock) begin
      duty_word_t due;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (duty_words_due.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               due = duty_words_due.pop_front();
               if (rsp_ch.pwm_duty !== due.duty)
                  report_mismatch($sformatf("pwm_duty %0d, expected %0d",
                                            rsp_ch.pwm_duty, due.duty));
               if (rsp_ch.status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, due.status));
               if (rsp_ch.output_loop_active !== due.out_loop)
                  report_mismatch($sformatf("output_loop_active %0b, expected %0b",
                                            rsp_ch.output_loop_active, due.out_loop));
               if (rsp_ch.saturated !== due.saturated)
                  report_mismatch($sformatf("saturated %0b, expected %0b",
                                            rsp_ch.saturated, due.saturated));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_SAMPLE;
      req_ch.vout_sample = '0;
      req_ch.vin_sample  = '0;
      req_ch.fault_n     = 1'b1;
      req_ch.vin_target  = '0;
      rsp_ch.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_TARGET_FLOOR;
      csr_wdata          = '0;
      ctl_cfg            = '{target_floor: '0, vout_limit: ADC_MAX, vout_abs_max: ADC_MAX,
                             vin_abs_min: '0, in_gains: '0, out_gains: '0, pwm_floor: '0,
                             pwm_ceiling: DUTY_MAX};
      clear_loops();
      tracking    = 1'b0;
      governs_out = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_commands();
      test_panic_order();
      test_field_extremes();
      test_floor_above_ceiling();
      test_backpressure();
      test_random_phase(TYPICAL, 0, 0, 350);
      test_random_phase(TYPICAL, 78, 0, 300);
      test_random_phase(TYPICAL, 0, 78, 300);
      test_random_phase(TYPICAL, 27, 27, 300);
      test_random_phase(WIDE_OPEN, 27, 27, 150);
      test_random_phase(PINCHED, 0, 0, 150);
      test_random_phase(TYPICAL, 0, 0, 300);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && duty_words_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> dual_pid_voltage_limit_controller.f
+incdir+sv
sv/dpvl_pkg.sv
sv/dpvl_if.sv
sv/dpvl_csr.sv
sv/dpvl_pid_loop.sv
sv/dual_pid_voltage_limit_controller.sv
sv/dpvl_checker.sv
dv/dual_pid_voltage_limit_controller_tb.sv
